// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the string escape decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge. The check is off while reset is high.
`define SED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, during reset as well.
`define SED_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
// Types, character codes and hex digit helpers for the string escape decoder.
`default_nettype none

package sed_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [1:0] status;
      logic       out_end;
   } rsp_type;

   // Escape mode, one-hot.
   typedef enum logic [3:0] {
      MODE_PLAIN = 4'b0001,
      MODE_ESC   = 4'b0010,
      MODE_HEX1  = 4'b0100,
      MODE_HEX2  = 4'b1000
   } mode_type;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_HEX    = 2'd2;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] high_nibble;
      logic [1:0] err;
   } state_type;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   // True for 0-9, a-f and A-F.
   function automatic logic is_hex(input logic [7:0] c);
      logic digit;
      logic lower;
      logic upper;
      digit = (c >= 8'h30) && (c <= 8'h39);
      lower = (c >= 8'h61) && (c <= 8'h66);
      upper = (c >= 8'h41) && (c <= 8'h46);
      return digit || lower || upper;
   endfunction

   // Value of a hex digit. A letter has a low nibble of 1 to 6, so adding 9 gives 10 to 15.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c[6]) begin
         v = c[3:0] + 4'd9;
      end else begin
         v = c[3:0];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sed_decode.sv =====
// Next-state and result logic for one string byte.
`default_nettype none

module sed_decode (
   input  var sed_pkg::state_type cur_state,
   input  var sed_pkg::req_type   item,
   output sed_pkg::state_type     nxt_state,
   output sed_pkg::rsp_type       result
);

   logic [7:0]        obyte;
   logic              ovalid;
   sed_pkg::state_type upd;

   always_comb begin
      upd    = cur_state;
      obyte  = 8'h00;
      ovalid = 1'b0;
      if (cur_state.err == sed_pkg::ERR_NONE) begin
         unique case (cur_state.mode)
            sed_pkg::MODE_PLAIN: begin
               if (item.in_byte == sed_pkg::CHAR_BACKSLASH) begin
                  // A backslash as the final byte cannot start an escape.
                  if (item.in_last) begin
                     upd.err = sed_pkg::ERR_ESCAPE;
                  end else begin
                     upd.mode = sed_pkg::MODE_ESC;
                  end
               end else begin
                  obyte  = item.in_byte;
                  ovalid = 1'b1;
               end
            end
            sed_pkg::MODE_ESC: begin
               upd.mode = sed_pkg::MODE_PLAIN;
               case (item.in_byte)
                  sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_QUOTE: begin
                     obyte  = item.in_byte;
                     ovalid = 1'b1;
                  end
                  sed_pkg::CHAR_N: begin
                     obyte  = sed_pkg::CHAR_LF;
                     ovalid = 1'b1;
                  end
                  sed_pkg::CHAR_R: begin
                     obyte  = sed_pkg::CHAR_CR;
                     ovalid = 1'b1;
                  end
                  sed_pkg::CHAR_T: begin
                     obyte  = sed_pkg::CHAR_TAB;
                     ovalid = 1'b1;
                  end
                  sed_pkg::CHAR_X: begin
                     if (item.in_last) begin
                        upd.err = sed_pkg::ERR_HEX;
                     end else begin
                        upd.mode = sed_pkg::MODE_HEX1;
                     end
                  end
                  default: begin
                     upd.err = sed_pkg::ERR_ESCAPE;
                  end
               endcase
            end
            sed_pkg::MODE_HEX1: begin
               // The string may not end on the first digit of a hex escape.
               if (!sed_pkg::is_hex(item.in_byte) || item.in_last) begin
                  upd.err  = sed_pkg::ERR_HEX;
                  upd.mode = sed_pkg::MODE_PLAIN;
               end else begin
                  upd.high_nibble = sed_pkg::hex_value(item.in_byte);
                  upd.mode        = sed_pkg::MODE_HEX2;
               end
            end
            sed_pkg::MODE_HEX2: begin
               upd.mode = sed_pkg::MODE_PLAIN;
               if (!sed_pkg::is_hex(item.in_byte)) begin
                  upd.err = sed_pkg::ERR_HEX;
               end else begin
                  obyte  = {cur_state.high_nibble, sed_pkg::hex_value(item.in_byte)};
                  ovalid = 1'b1;
               end
            end
            default: begin
               upd.mode = sed_pkg::MODE_PLAIN;
            end
         endcase
      end

      result.out_byte  = obyte;
      result.out_valid = ovalid;
      result.status    = upd.err;
      result.out_end   = item.in_last;

      // The final byte closes the string and clears all state.
      if (item.in_last) begin
         nxt_state.mode        = sed_pkg::MODE_PLAIN;
         nxt_state.high_nibble = 4'h0;
         nxt_state.err         = sed_pkg::ERR_NONE;
      end else begin
         nxt_state = upd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/string_escape_decoder.sv =====
// Top level of the string escape decoder: input register, decode state and result register.
`default_nettype none
`include "assert_macros.svh"

// Channel   Ports                          Payload    Role
// request   req_valid, req_stall, req_data req_type   one string body byte and its last flag
// response  rsp_valid, rsp_stall, rsp_data rsp_type   decoded byte, valid, status and end mark
//
// A request passes through the input register and then the response register on its
// way to its response. A new request can be accepted every cycle while req_stall is low.
// Reset clears the escape mode, the stored hex nibble, the sticky error and both valid flags.
// When rsp_stall holds a response, the request in the input register waits and
// req_stall rises; while the input register is empty a request is still taken.

module string_escape_decoder (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output logic                 req_stall,
   input  var sed_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  var logic             rsp_stall,
   output sed_pkg::rsp_type     rsp_data
);

   // Input register.
   logic             in_valid_ff;
   logic             in_valid_in;
   sed_pkg::req_type in_ff;

   // Decoder state; it advances once per request, when the request moves to the response.
   sed_pkg::state_type state_ff;
   sed_pkg::state_type state_in;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   sed_pkg::rsp_type rsp_ff;
   sed_pkg::rsp_type rsp_in;

   logic accept;
   logic advance;

   // The held request moves on when the response register is empty or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   sed_decode u_decode (
      .cur_state (state_ff),
      .item      (in_ff),
      .nxt_state (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff.mode        <= sed_pkg::MODE_PLAIN;
         state_ff.high_nibble <= 4'h0;
         state_ff.err         <= sed_pkg::ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A decoded byte only appears while the string has no error.
   `SED_ASSERT(a_valid_needs_ok,
      rsp_valid_ff && rsp_ff.out_valid |-> rsp_ff.status == sed_pkg::ERR_NONE,
      "decoded byte delivered with an error status")
   // A response without a decoded byte carries a zero byte.
   `SED_ASSERT(a_idle_byte_zero,
      rsp_valid_ff && !rsp_ff.out_valid |-> rsp_ff.out_byte == 8'h00,
      "nonzero byte in a response without a decoded byte")
   // The final byte of a string leaves the decoder clean.
   `SED_ASSERT(a_end_clears,
      advance && in_ff.in_last |=>
         state_ff.mode == sed_pkg::MODE_PLAIN && state_ff.err == sed_pkg::ERR_NONE,
      "state not cleared after the final byte")
   // An error stays until the string ends.
   `SED_ASSERT(a_error_sticky,
      advance && state_ff.err != sed_pkg::ERR_NONE && !in_ff.in_last |=>
         state_ff.err == $past(state_ff.err),
      "sticky error changed before the end of the string")

endmodule

`default_nettype wire
